/* src/bfm3_pkg.sv */
// Shared constants, types and state codes for the bloom filter with murmur3 hashing.
// No dependencies.
`default_nettype none
package bfm3_pkg;
  localparam int MaxHashes = 8;
  localparam int MaxWords  = 1024;

  localparam int LaneW = (MaxHashes > 1) ? $clog2(MaxHashes) : 1;
  localparam int NhW   = $clog2(MaxHashes + 1);
  localparam int NwW   = $clog2(MaxWords + 1);
  localparam int AddrW = (MaxWords > 1) ? $clog2(MaxWords) : 1;
  localparam int DvdW  = 26;
  localparam int CntW  = 5;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 11;
  localparam logic [CfgIdxW-1:0] CfgNumHashes = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgNumWords  = 2'd1;

  localparam logic [3:0]      NumHashesRst = 4'd3;
  localparam logic [NwW-1:0]  NumWordsRst  = NwW'(1024);
  localparam logic [31:0]     SeedBase     = 32'd51;
  localparam logic [15:0]     MaxLen       = 16'hffff;

  localparam logic [31:0] C1 = 32'hcc9e2d51;
  localparam logic [31:0] C2 = 32'h1b873593;
  localparam logic [31:0] C3 = 32'he6546b64;
  localparam logic [31:0] F1 = 32'h85ebca6b;
  localparam logic [31:0] F2 = 32'hc2b2ae35;

  typedef enum logic [11:0] {
    StClr  = 12'b0000_0000_0001,
    StIdle = 12'b0000_0000_0010,
    StK1   = 12'b0000_0000_0100,
    StK2   = 12'b0000_0000_1000,
    StBlk  = 12'b0000_0001_0000,
    StF0   = 12'b0000_0010_0000,
    StF1   = 12'b0000_0100_0000,
    StF2   = 12'b0000_1000_0000,
    StDiv  = 12'b0001_0000_0000,
    StRd   = 12'b0010_0000_0000,
    StWr   = 12'b0100_0000_0000,
    StOut  = 12'b1000_0000_0000
  } state_e;
endpackage
`default_nettype wire

/* src/bfm3_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none
module bfm3_ram #(
  parameter int Width = 64,
  parameter int Depth = 1024
) (
  input  wire logic                              clk_i,
  input  wire logic                              we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] addr_i,
  input  wire logic [Width-1:0]                  wdata_i,
  output logic      [Width-1:0]                  rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

/* src/bloom_filter_murmur3.sv */
// Bloom filter top level: per-byte murmur3 x86_32 lanes, bit store in RAM.
// Depends on bfm3_pkg and bfm3_ram.
// A byte that completes a 4-byte block passes StK1, StK2 and StBlk; other non-last bytes are taken in StIdle alone.
// Last byte: scrambled in StK1 and StK2 (and StBlk when it completes a block), then per hash lane:
// mix in StF0-StF2, the bit-serial modulo by the word count in StDiv, the store RMW in StRd/StWr; then StOut.
// Reset: async, active low; a clearing pass zeroes every store word, in_stall_o high.
`default_nettype none
module bloom_filter_murmur3 import bfm3_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                req_type_i,
  input  wire logic [7:0]          key_byte_i,
  input  wire logic                last_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic                     found_o,
  output logic                     too_long_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);
  state_e state_q, state_d;

  logic [3:0]       nh_cfg_q;
  logic [NwW-1:0]   nw_cfg_q;
  logic [NhW-1:0]   nh_eff;
  logic [NwW-1:0]   nw_eff;

  logic [31:0]      acc_q [MaxHashes];
  logic [23:0]      blk_q, blk_d;
  logic [1:0]       fill_q, fill_d;
  logic [15:0]      len_q, len_d;
  logic             ovf_q, ovf_d;
  logic             last_q, last_d, req_q, req_d, tail_q, tail_d, found_q, found_d;
  logic [31:0]      k_q, k_d, mul_q, mul_d, mop, mconst, h0, h1, h2;
  logic [LaneW-1:0] lane_q, lane_d;
  logic [DvdW-1:0]  dvd_q, dvd_d;
  logic [NwW-1:0]   rem_q, rem_d;
  logic [NwW:0]     trial;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [5:0]       bit_q, bit_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic             out_valid_q, out_valid_d, found_out_q, found_out_d, ovf_out_q, ovf_out_d;
  logic             key_rst, blk_upd;

  logic             ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [63:0]      ram_wdata, ram_rdata;

  bfm3_ram #(.Width(64), .Depth(MaxWords)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    if (nh_cfg_q == 4'd0) begin
      nh_eff = NhW'(1);
    end else if (32'(nh_cfg_q) > MaxHashes) begin
      nh_eff = NhW'(MaxHashes);
    end else begin
      nh_eff = NhW'(nh_cfg_q);
    end
    if (nw_cfg_q == '0) begin
      nw_eff = NwW'(1);
    end else if (32'(nw_cfg_q) > MaxWords) begin
      nw_eff = NwW'(MaxWords);
    end else begin
      nw_eff = nw_cfg_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nh_cfg_q <= NumHashesRst;
      nw_cfg_q <= NumWordsRst;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgNumHashes) begin
        nh_cfg_q <= cfg_data_i[3:0];
      end else if (cfg_index_i == CfgNumWords) begin
        nw_cfg_q <= NwW'(cfg_data_i);
      end
    end
  end

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != StIdle);

  // finalization mix stages and the trial remainder for the modulo
  always_comb begin
    h0 = acc_q[lane_q] ^ (tail_q ? k_q : 32'd0) ^ {16'd0, len_q};
    h0 = h0 ^ (h0 >> 16);
    h1 = mul_q ^ (mul_q >> 13);
    h2 = mul_q ^ (mul_q >> 16);
    trial = {rem_q, dvd_q[DvdW-1]};
  end

  always_comb begin
    mop    = k_q;
    mconst = C1;
    unique case (state_q)
      StK2:    begin mop = {mul_q[16:0], mul_q[31:17]}; mconst = C2; end
      StF0:    begin mop = h0; mconst = F1; end
      StF1:    begin mop = h1; mconst = F2; end
      default: begin mop = k_q; mconst = C1; end
    endcase
    mul_d = 32'(mop * mconst);
  end

  always_comb begin
    state_d     = state_q;
    blk_d       = blk_q;
    fill_d      = fill_q;
    len_d       = len_q;
    ovf_d       = ovf_q;
    last_d      = last_q;
    req_d       = req_q;
    tail_d      = tail_q;
    found_d     = found_q;
    k_d         = k_q;
    lane_d      = lane_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    bit_d       = bit_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q & out_stall_i;
    found_out_d = found_out_q;
    ovf_out_d   = ovf_out_q;
    key_rst     = 1'b0;
    blk_upd     = 1'b0;
    ram_we      = 1'b0;
    ram_addr    = rem_q[AddrW-1:0];
    ram_wdata   = ram_rdata | (64'd1 << bit_q);

    unique case (state_q)
      StClr: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + AddrW'(1);
        if (clr_q == AddrW'(MaxWords - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_valid_i) begin
          if (len_q == MaxLen) begin
            ovf_d = 1'b1;
          end else begin
            len_d = len_q + 16'd1;
          end
          last_d  = last_i;
          req_d   = req_type_i;
          found_d = 1'b1;
          lane_d  = '0;
          if (fill_q == 2'd3) begin
            k_d     = {key_byte_i, blk_q};
            tail_d  = 1'b0;
            state_d = StK1;
          end else begin
            unique case (fill_q)
              2'd0:    blk_d[7:0]   = key_byte_i;
              2'd1:    blk_d[15:8]  = key_byte_i;
              default: blk_d[23:16] = key_byte_i;
            endcase
            fill_d = fill_q + 2'd1;
            if (last_i) begin
              k_d     = {8'd0, blk_d};
              tail_d  = 1'b1;
              state_d = StK1;
            end
          end
        end
      end
      StK1: state_d = StK2;
      StK2: begin
        k_d     = mul_d;
        state_d = tail_q ? StF0 : StBlk;
      end
      StBlk: begin
        blk_upd = 1'b1;
        blk_d   = '0;
        fill_d  = '0;
        state_d = last_q ? StF0 : StIdle;
      end
      StF0: state_d = StF1;
      StF1: state_d = StF2;
      StF2: begin
        dvd_d   = h2[31:6];
        bit_d   = h2[5:0];
        rem_d   = '0;
        cnt_d   = CntW'(DvdW - 1);
        state_d = StDiv;
      end
      StDiv: begin
        if (trial >= {1'b0, nw_eff}) begin
          rem_d = NwW'(trial - {1'b0, nw_eff});
        end else begin
          rem_d = NwW'(trial);
        end
        dvd_d = {dvd_q[DvdW-2:0], 1'b0};
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == '0) begin
          state_d = StRd;
        end
      end
      StRd: state_d = StWr;
      StWr: begin
        if (!req_q) begin
          ram_we = 1'b1;
        end else if (!ram_rdata[bit_q]) begin
          found_d = 1'b0;
        end
        lane_d = lane_q + LaneW'(1);
        if (NhW'(lane_q) + NhW'(1) == nh_eff) begin
          state_d = StOut;
        end else begin
          state_d = StF0;
        end
      end
      StOut: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          found_out_d = req_q & found_q;
          ovf_out_d   = ovf_q;
          key_rst     = 1'b1;
          blk_d       = '0;
          fill_d      = '0;
          len_d       = '0;
          ovf_d       = 1'b0;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClr;
      clr_q       <= '0;
      blk_q       <= '0;
      fill_q      <= '0;
      len_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MaxHashes; i++) begin
        acc_q[i] <= SeedBase + 32'(i);
      end
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      blk_q       <= blk_d;
      fill_q      <= fill_d;
      len_q       <= len_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      for (int i = 0; i < MaxHashes; i++) begin
        if (key_rst) begin
          acc_q[i] <= SeedBase + 32'(i);
        end else if (blk_upd) begin
          acc_q[i] <= ({acc_q[i][18:0] ^ k_q[18:0], acc_q[i][31:19] ^ k_q[31:19]} << 2)
                    + {acc_q[i][18:0] ^ k_q[18:0], acc_q[i][31:19] ^ k_q[31:19]} + C3;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    last_q      <= last_d;
    req_q       <= req_d;
    tail_q      <= tail_d;
    found_q     <= found_d;
    k_q         <= k_d;
    mul_q       <= mul_d;
    lane_q      <= lane_d;
    dvd_q       <= dvd_d;
    rem_q       <= rem_d;
    cnt_q       <= cnt_d;
    bit_q       <= bit_d;
    found_out_q <= found_out_d;
    ovf_out_q   <= ovf_out_d;
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_out_q;
  assign too_long_o  = ovf_out_q;
endmodule
`default_nettype wire

/* src/bfm3_chk.sv */
// Port-level checker for bloom_filter_murmur3, attached by bind.
// Depends on bfm3_pkg.
`default_nettype none
module bfm3_chk import bfm3_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire logic                last_i,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire logic                found_o,
  input wire logic                too_long_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(found_o) && $stable(too_long_o))
    else $error("stalled result beat changed");

  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !last_i && !out_valid_o |=> !out_valid_o)
    else $error("result without a last byte");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_i |=> in_stall_o)
    else $error("last byte did not start finalization");

  a_clear_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> in_stall_o && !out_valid_o)
    else $error("input taken during clearing pass");
endmodule

bind bloom_filter_murmur3 bfm3_chk u_bfm3_chk (.*);
`default_nettype wire
